>>> rtl/core/stse_pkg.sv
// Package for the strided tensor scan engine.
// Holds the sizes, the operation, status, config index and result kind codes,
// and the controller/datapath structs. No dependencies.
package stse_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int MEM_DEPTH  = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = 10;
  localparam int EXT_W      = 11;
  localparam int STR_W      = 10;
  localparam int DIM_W      = 2;
  localparam int ND_W       = 3;
  localparam int SPAN_W     = EXT_W + STR_W;
  localparam int MAXA_W     = SPAN_W + DIM_W + 1;
  localparam int CFG_W      = 10;

  // Operation codes
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Run status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_AXIS = 2'd1;
  localparam logic [1:0] ST_TOO_MANY = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_DIM_CNT   = 2'd0;
  localparam logic [1:0] CFG_SCAN_DIM  = 2'd1;
  localparam logic [1:0] CFG_BASE_OFF  = 2'd2;
  localparam logic [1:0] CFG_SCAN_MODE = 2'd3;

  // Result kinds
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic             set_desc;
    logic             src_wr;
    logic             res_rd;
    logic             run_init;
    logic             chk_step;
    logic             ord_step;
    logic             line_start;
    logic             elem_rd;
    logic             acc_en;
    logic             acc_copy;
    logic             elem_wr;
    logic             adv_inc;
    logic             adv_wrap;
    logic             out_load;
    logic             out_kind;
    logic [1:0]       out_status;
    logic [DIM_W-1:0] sel;
  } stse_cmd_t;

  typedef struct packed {
    logic [ND_W-1:0]  dim_cnt;
    logic [DIM_W-1:0] scan_dim;
    logic             any_zero;
    logic             too_many;
    logic             range_bad;
    logic             last_elem;
    logic             can_inc;
    logic             out_free;
  } stse_stat_t;

endpackage

>>> rtl/core/strided_tensor_scan_engine_top.sv
// Strided tensor scan engine, top level. Set and write transactions are applied on
// acceptance; a read returns its data through the registered result-memory read and
// the output register. A run checks each dimension, orders the result strides and
// responds, scanning each element by a registered memory read, accumulate and write,
// with a start step and odometer steps per line. One item at a time. Reset is
// asynchronous active low; the memories are not cleared, descriptor tables reset to zero.
module strided_tensor_scan_engine_top #(
  parameter int DATA_WIDTH = stse_pkg::DATA_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 in_opcode_i,
  input  logic [1:0]                 in_dim_index_i,
  input  logic [10:0]                in_extent_i,
  input  logic [9:0]                 in_stride_i,
  input  logic [9:0]                 in_address_i,
  input  logic [31:0]                in_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       out_result_kind_o,
  output logic [31:0]                out_value_res_o,
  output logic [1:0]                 out_status_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [stse_pkg::CFG_W-1:0] cfg_wdata_i
);
  import stse_pkg::*;

  stse_cmd_t  cmd;
  stse_stat_t stat;

  stse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_opcode_i(in_opcode_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  stse_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_dim_index_i   (in_dim_index_i),
    .in_extent_i      (in_extent_i),
    .in_stride_i      (in_stride_i),
    .in_address_i     (in_address_i),
    .in_value_i       (in_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_result_kind_o(out_result_kind_o),
    .out_value_res_o  (out_value_res_o),
    .out_status_o     (out_status_o)
  );

endmodule

>>> rtl/core/stse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/stse_dp.sv
// Datapath: configuration, descriptor tables, odometer, address and scan arithmetic,
// source and result memories, output register. Depends on stse_pkg and stse_ram.
module stse_dp #(
  parameter int DATA_WIDTH = stse_pkg::DATA_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  stse_pkg::stse_cmd_t       cmd_i,
  output stse_pkg::stse_stat_t      stat_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [stse_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic [1:0]                in_dim_index_i,
  input  logic [10:0]               in_extent_i,
  input  logic [9:0]                in_stride_i,
  input  logic [9:0]                in_address_i,
  input  logic [31:0]               in_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      out_result_kind_o,
  output logic [31:0]               out_value_res_o,
  output logic [1:0]                out_status_o
);
  import stse_pkg::*;

  localparam logic SCAN_SUM_C = 1'b0;

  // configuration registers
  logic [ND_W-1:0]   dim_cnt_q;
  logic [DIM_W-1:0]  scan_dim_q;
  logic [ADDR_W-1:0] base_q;
  logic              mode_q;

  // descriptor and derived tables
  logic [EXT_W-1:0]  ext_q   [MAX_DIMS];
  logic [STR_W-1:0]  str_q   [MAX_DIMS];
  logic [ADDR_W-1:0] span_q  [MAX_DIMS];
  logic [ADDR_W-1:0] ospan_q [MAX_DIMS];
  logic [EXT_W-1:0]  ost_q   [MAX_DIMS];
  logic [EXT_W-1:0]  coord_q [MAX_DIMS];

  // run state
  logic              any_zero_q, too_many_q;
  logic [EXT_W-1:0]  total_q, prod_q, s_q;
  logic [MAXA_W-1:0] maxaddr_q;
  logic [ADDR_W-1:0] line_src_q, line_dst_q, elem_src_q, elem_dst_q;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;

  // output register
  logic              out_valid_q, out_kind_q;
  logic [1:0]        out_status_q;
  logic [31:0]       out_value_q;

  logic [DATA_WIDTH-1:0] src_rdata, res_rdata;
  logic [DATA_WIDTH-1:0] in_value_w;
  logic [EXT_W-1:0]      ext_s, ost_s, coord_s;
  logic [STR_W-1:0]      str_s;
  logic [2*EXT_W-1:0]    tot_prod, ord_prod;
  logic [SPAN_W-1:0]     span_full;
  logic [2*DATA_WIDTH-1:0] mul_full;
  logic                  out_free;

  assign ext_s   = ext_q[cmd_i.sel];
  assign str_s   = str_q[cmd_i.sel];
  assign ost_s   = ost_q[cmd_i.sel];
  assign coord_s = coord_q[cmd_i.sel];

  assign tot_prod  = total_q * ext_s;
  assign ord_prod  = prod_q * ext_s;
  assign span_full = (ext_s - EXT_W'(1)) * str_s;
  assign in_value_w = DATA_WIDTH'(in_value_i);

  // scan operator
  assign mul_full = acc_q * src_rdata;
  always_comb begin
    if (cmd_i.acc_copy) begin
      acc_d = src_rdata;
    end else if (mode_q) begin
      acc_d = mul_full[DATA_WIDTH-1:0];
    end else begin
      acc_d = acc_q + src_rdata;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_cnt_q  <= ND_W'(1);
      scan_dim_q <= '0;
      base_q     <= '0;
      mode_q     <= SCAN_SUM_C;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIM_CNT:   dim_cnt_q  <= cfg_wdata_i[ND_W-1:0];
        CFG_SCAN_DIM:  scan_dim_q <= cfg_wdata_i[DIM_W-1:0];
        CFG_BASE_OFF:  base_q     <= cfg_wdata_i[ADDR_W-1:0];
        CFG_SCAN_MODE: mode_q     <= cfg_wdata_i[0];
      endcase
    end
  end

  // descriptor tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        ext_q[i] <= '0;
        str_q[i] <= '0;
      end
    end else if (cmd_i.set_desc) begin
      ext_q[in_dim_index_i] <= in_extent_i;
      str_q[in_dim_index_i] <= in_stride_i;
    end
  end

  // check and ordering passes, odometer, scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_zero_q <= 1'b0;
      too_many_q <= 1'b0;
    end else if (cmd_i.run_init) begin
      any_zero_q <= 1'b0;
      too_many_q <= 1'b0;
    end else if (cmd_i.chk_step) begin
      if (ext_s == '0) any_zero_q <= 1'b1;
      if (!too_many_q && tot_prod > (2*EXT_W)'(MEM_DEPTH)) too_many_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_init) begin
      total_q    <= EXT_W'(1);
      prod_q     <= EXT_W'(1);
      maxaddr_q  <= MAXA_W'(base_q);
      line_src_q <= base_q;
      line_dst_q <= '0;
      elem_src_q <= base_q;
      elem_dst_q <= '0;
      for (int i = 0; i < MAX_DIMS; i++) coord_q[i] <= '0;
    end
    if (cmd_i.chk_step) begin
      if (!too_many_q && tot_prod <= (2*EXT_W)'(MEM_DEPTH)) total_q <= tot_prod[EXT_W-1:0];
      maxaddr_q           <= maxaddr_q + MAXA_W'(span_full);
      span_q[cmd_i.sel]   <= span_full[ADDR_W-1:0];
    end
    if (cmd_i.ord_step) begin
      ost_q[cmd_i.sel]   <= prod_q;
      prod_q             <= ord_prod[EXT_W-1:0];
      ospan_q[cmd_i.sel] <= ADDR_W'(ord_prod[EXT_W-1:0] - prod_q);
    end
    if (cmd_i.line_start) begin
      elem_src_q <= line_src_q;
      elem_dst_q <= line_dst_q;
      s_q        <= '0;
      acc_q      <= mode_q ? DATA_WIDTH'(1) : '0;
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.elem_wr) begin
      elem_src_q <= elem_src_q + ADDR_W'(str_s);
      elem_dst_q <= elem_dst_q + ost_s[ADDR_W-1:0];
      s_q        <= s_q + EXT_W'(1);
    end
    if (cmd_i.adv_inc) begin
      coord_q[cmd_i.sel] <= coord_s + EXT_W'(1);
      line_src_q         <= line_src_q + ADDR_W'(str_s);
      line_dst_q         <= line_dst_q + ost_s[ADDR_W-1:0];
    end
    if (cmd_i.adv_wrap) begin
      coord_q[cmd_i.sel] <= '0;
      line_src_q         <= line_src_q - span_q[cmd_i.sel];
      line_dst_q         <= line_dst_q - ospan_q[cmd_i.sel];
    end
  end

  // memories
  stse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MEM_DEPTH)) u_src_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.src_wr),
    .waddr_i($clog2(MEM_DEPTH)'(in_address_i)),
    .wdata_i(in_value_w),
    .re_i   (cmd_i.elem_rd),
    .raddr_i($clog2(MEM_DEPTH)'(elem_src_q)),
    .rdata_o(src_rdata)
  );

  stse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MEM_DEPTH)) u_res_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.elem_wr),
    .waddr_i($clog2(MEM_DEPTH)'(elem_dst_q)),
    .wdata_i(acc_q),
    .re_i   (cmd_i.res_rd),
    .raddr_i($clog2(MEM_DEPTH)'(in_address_i)),
    .rdata_o(res_rdata)
  );

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q   <= cmd_i.out_kind;
      out_status_q <= cmd_i.out_status;
      out_value_q  <= (cmd_i.out_kind == KIND_READ) ? 32'(res_rdata) : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_result_kind_o = out_kind_q;
  assign out_status_o      = out_status_q;
  assign out_value_res_o   = out_value_q;

  // status to the controller
  assign stat_o.dim_cnt   = dim_cnt_q;
  assign stat_o.scan_dim  = scan_dim_q;
  assign stat_o.any_zero  = any_zero_q;
  assign stat_o.too_many  = too_many_q;
  assign stat_o.range_bad = (maxaddr_q >= MAXA_W'(MEM_DEPTH));
  assign stat_o.last_elem = (({1'b0, s_q} + (EXT_W+1)'(1)) == {1'b0, ext_s});
  assign stat_o.can_inc   = (({1'b0, coord_s} + (EXT_W+1)'(1)) < {1'b0, ext_s});
  assign stat_o.out_free  = out_free;

endmodule

>>> rtl/core/stse_ctrl.sv
// Controller state machine: command decode, check and ordering passes, line walk and response.
// Depends on stse_pkg.
module stse_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           in_opcode_i,
  input  stse_pkg::stse_stat_t stat_i,
  output stse_pkg::stse_cmd_t  cmd_o
);
  import stse_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_ORDER  = 4'd3;
  localparam logic [3:0] S_LINE   = 4'd4;
  localparam logic [3:0] S_READ   = 4'd5;
  localparam logic [3:0] S_ACC    = 4'd6;
  localparam logic [3:0] S_WRITE  = 4'd7;
  localparam logic [3:0] S_ADV    = 4'd8;
  localparam logic [3:0] S_RDWAIT = 4'd9;
  localparam logic [3:0] S_RESP   = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [DIM_W-1:0] k_q, k_d;
  logic [1:0]       status_q, status_d;
  logic             kind_q, kind_d;
  logic             scalar_q, scalar_d;
  logic             accept;
  logic [DIM_W-1:0] k_top;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign k_top      = DIM_W'(stat_i.dim_cnt - ND_W'(1));

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    status_d = status_q;
    kind_d   = kind_q;
    scalar_d = scalar_q;
    cmd_o    = '0;
    cmd_o.sel        = k_q;
    cmd_o.out_kind   = kind_q;
    cmd_o.out_status = status_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_opcode_i)
            OP_SET:   cmd_o.set_desc = 1'b1;
            OP_WRITE: cmd_o.src_wr   = 1'b1;
            OP_RUN: begin
              cmd_o.run_init = 1'b1;
              kind_d   = KIND_RUN;
              status_d = ST_OK;
              scalar_d = 1'b0;
              k_d      = '0;
              if (stat_i.dim_cnt == '0) begin
                scalar_d = 1'b1;
                state_d  = S_READ;
              end else if (stat_i.dim_cnt > ND_W'(MAX_DIMS) ||
                           ND_W'(stat_i.scan_dim) >= stat_i.dim_cnt) begin
                status_d = ST_BAD_AXIS;
                state_d  = S_RESP;
              end else begin
                state_d = S_CHECK;
              end
            end
            OP_READ: begin
              cmd_o.res_rd = 1'b1;
              kind_d   = KIND_READ;
              status_d = ST_OK;
              state_d  = S_RDWAIT;
            end
          endcase
        end
      end
      // one dimension a cycle: zero extent, element count, source span
      S_CHECK: begin
        cmd_o.chk_step = 1'b1;
        if (k_q == k_top) state_d = S_DECIDE;
        else k_d = k_q + DIM_W'(1);
      end
      S_DECIDE: begin
        priority if (stat_i.any_zero) begin
          status_d = ST_OK;
          state_d  = S_RESP;
        end else if (stat_i.too_many) begin
          status_d = ST_TOO_MANY;
          state_d  = S_RESP;
        end else if (stat_i.range_bad) begin
          status_d = ST_RANGE;
          state_d  = S_RESP;
        end else begin
          k_d     = k_top;
          state_d = S_ORDER;
        end
      end
      // result strides, innermost first
      S_ORDER: begin
        cmd_o.ord_step = 1'b1;
        if (k_q == '0) state_d = S_LINE;
        else k_d = k_q - DIM_W'(1);
      end
      S_LINE: begin
        cmd_o.line_start = 1'b1;
        state_d = S_READ;
      end
      S_READ: begin
        cmd_o.elem_rd = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_en   = 1'b1;
        cmd_o.acc_copy = scalar_q;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.elem_wr = 1'b1;
        cmd_o.sel     = stat_i.scan_dim;
        if (scalar_q) begin
          state_d = S_RESP;
        end else if (stat_i.last_elem) begin
          k_d     = k_top;
          state_d = S_ADV;
        end else begin
          state_d = S_READ;
        end
      end
      // odometer over the non-scan axes, last axis fastest
      S_ADV: begin
        if (k_q == stat_i.scan_dim) begin
          if (k_q == '0) state_d = S_RESP;
          else k_d = k_q - DIM_W'(1);
        end else if (stat_i.can_inc) begin
          cmd_o.adv_inc = 1'b1;
          state_d = S_LINE;
        end else begin
          cmd_o.adv_wrap = 1'b1;
          if (k_q == '0) state_d = S_RESP;
          else k_d = k_q - DIM_W'(1);
        end
      end
      S_RDWAIT: state_d = S_RESP;
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      k_q      <= '0;
      status_q <= ST_OK;
      kind_q   <= KIND_RUN;
      scalar_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      status_q <= status_d;
      kind_q   <= kind_d;
      scalar_q <= scalar_d;
    end
  end

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free) else $error("output overwritten");

  // a read transaction reaches the response state through the read-wait state
  a_read_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_opcode_i == OP_READ) |-> ##2 (state_q == S_RESP))
    else $error("read response lost");

  // the check pass only visits dimensions in use
  a_chk_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.chk_step |-> (ND_W'(k_q) < stat_i.dim_cnt)) else $error("check past last dim");

  // scanned elements are only written after an accumulate
  a_wr_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.elem_wr |-> $past(cmd_o.acc_en)) else $error("write without accumulate");

endmodule
